[sv/tsce_pkg.sv]
// ----------------------------------------------------------------------------
// tsce_pkg
// Shared codes and types of the transport server connection engine.
// ----------------------------------------------------------------------------
package tsce_pkg;

  localparam logic [2:0] ACT_HEADER  = 3'd0;
  localparam logic [2:0] ACT_PAYLOAD = 3'd1;
  localparam logic [2:0] ACT_TICK    = 3'd2;
  localparam logic [2:0] ACT_OPEN    = 3'd3;
  localparam logic [2:0] ACT_LISTEN  = 3'd4;
  localparam logic [2:0] ACT_CLOSE   = 3'd5;
  localparam logic [2:0] ACT_READ    = 3'd6;

  localparam logic [2:0] T_SYN     = 3'd0;
  localparam logic [2:0] T_SYNACK  = 3'd1;
  localparam logic [2:0] T_FIN     = 3'd2;
  localparam logic [2:0] T_FINACK  = 3'd3;
  localparam logic [2:0] T_DATA    = 3'd4;
  localparam logic [2:0] T_DATAACK = 3'd5;

  localparam logic [1:0] CS_CLOSED = 2'd0;
  localparam logic [1:0] CS_LISTEN = 2'd1;
  localparam logic [1:0] CS_CONN   = 2'd2;
  localparam logic [1:0] CS_CWAIT  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_USED    = 3'd1;
  localparam logic [2:0] ST_NOSOCK  = 3'd2;
  localparam logic [2:0] ST_WRONG   = 3'd3;
  localparam logic [2:0] ST_NODATA  = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  localparam logic [1:0] RK_SEG    = 2'd0;
  localparam logic [1:0] RK_STATUS = 2'd1;
  localparam logic [1:0] RK_BYTE   = 2'd2;

  localparam int MAX_READ = 64;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DEC   = 7'b0000100,
    S_TICK  = 7'b0001000,
    S_RDREQ = 7'b0010000,
    S_RDOUT = 7'b0100000,
    S_DONE  = 7'b1000000
  } fsm_t;

endpackage

[sv/transport_server_connection_engine.sv]
// ----------------------------------------------------------------------------
// transport_server_connection_engine
// Server-side connection table with SYN/FIN/DATA handling and ring buffers.
// ----------------------------------------------------------------------------
// Timing: header, open and tick requests scan one slot a cycle; listen, close
//   and payload decide directly in S_DEC; a read then fetches each byte from
//   the buffer (S_RDREQ) and outputs it (S_RDOUT), byte by byte.
// Throughput: one request at a time; busy is high while a request works.
// Results cannot be stalled: each shows for one cycle under out_valid.
// Reset (rst_n low, synchronous) frees every slot; buffer data is left as is.
module transport_server_connection_engine import tsce_pkg::*; #(
  parameter int NUM_CONNS = 8,
  parameter int BUF_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_src_node,
  input  logic [2:0]  in_seg_type,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dest_port,
  input  logic [31:0] in_seq_num,
  input  logic [12:0] in_seg_length,
  input  logic [7:0]  in_payload_byte,
  input  logic [2:0]  in_socket_id,
  input  logic [15:0] in_open_port,
  input  logic [6:0]  in_read_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_status,
  output logic [2:0]  out_type,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dest_port,
  output logic [7:0]  out_dest_node,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic [2:0]  out_socket_out,
  output logic [7:0]  out_read_byte,
  output logic        out_last
);

  localparam int SW  = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;
  localparam int CW  = $clog2(NUM_CONNS + 1);
  localparam int PW  = $clog2(BUF_BYTES);
  localparam int BW  = PW + 1;
  localparam int LW  = ((BW > 13) ? BW : 13) + 1;
  localparam int AW  = SW + PW;
  localparam int MEMD = NUM_CONNS * BUF_BYTES;

  // connection table
  logic [NUM_CONNS-1:0] used_r;
  logic [1:0]  cstate_r [NUM_CONNS];
  logic [15:0] lport_r  [NUM_CONNS];
  logic [15:0] rport_r  [NUM_CONNS];
  logic [7:0]  rnode_r  [NUM_CONNS];
  logic [31:0] eseq_r   [NUM_CONNS];
  logic [BW-1:0] bcnt_r [NUM_CONNS];
  logic [PW-1:0] rptr_r [NUM_CONNS];
  logic [15:0] timer_r  [NUM_CONNS];
  logic [7:0]  mem [MEMD];

  logic [15:0] cwt_r;
  logic [SW-1:0] pslot_r;
  logic [12:0] prem_r;

  fsm_t state_r;
  logic [2:0]  act_r, typ_r;
  logic [7:0]  node_r, pbyte_r;
  logic [15:0] sp_r, dp_r, oport_r;
  logic [31:0] seq_r;
  logic [12:0] len_r;
  logic [2:0]  sock_r;
  logic [6:0]  nread_r;
  logic [CW-1:0] idx_r;
  logic        found_r, hitport_r, freefound_r;
  logic [SW-1:0] hit_r, free_r;
  logic [6:0]  rcnt_r;

  // output registers
  logic        ov_r, olast_r;
  logic [1:0]  okind_r;
  logic [2:0]  ostat_r, otype_r, osock_r;
  logic [15:0] osp_r, odp_r;
  logic [7:0]  onode_r, obyte_r;
  logic [31:0] oseq_r, oack_r;

  logic [SW-1:0] idx;
  logic [SW-1:0] sid;
  logic          sid_ok;
  logic          slot_match;
  logic [LW-1:0] sum_len;
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;

  assign idx = idx_r[SW-1:0];
  assign sid = SW'(sock_r);
  assign sid_ok = ({29'd0, sock_r} < 32'(NUM_CONNS)) && used_r[sid];
  assign slot_match = used_r[idx] && (lport_r[idx] == dp_r) &&
                      ((typ_r == T_SYN) || (rport_r[idx] == sp_r));
  assign sum_len = LW'(len_r) + LW'(bcnt_r[hit_r]);
  assign rd_addr = {sid, rptr_r[sid]};

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  // buffer memory: write payload, registered read
  always_ff @(posedge clk) begin
    if (state_r == S_DEC && act_r == ACT_PAYLOAD && prem_r != 13'd0 &&
        bcnt_r[pslot_r] < BW'(BUF_BYTES))
      mem[{pslot_r, PW'(rptr_r[pslot_r] + bcnt_r[pslot_r][PW-1:0])}] <= pbyte_r;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    ov_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      cwt_r   <= 16'd1000;
      prem_r  <= '0;
      pslot_r <= '0;
      for (int i = 0; i < NUM_CONNS; i++) begin
        cstate_r[i] <= CS_CLOSED; lport_r[i] <= '0; rport_r[i] <= '0;
        rnode_r[i] <= '0; eseq_r[i] <= '0; bcnt_r[i] <= '0;
        rptr_r[i] <= '0; timer_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) cwt_r <= cfg_data;
      case (state_r)
        // capture request
        S_IDLE: begin
          if (start) begin
            act_r <= in_action; typ_r <= in_seg_type; node_r <= in_src_node;
            sp_r <= in_src_port; dp_r <= in_dest_port; seq_r <= in_seq_num;
            len_r <= in_seg_length; pbyte_r <= in_payload_byte;
            sock_r <= in_socket_id; oport_r <= in_open_port;
            nread_r <= (in_read_length > 7'(MAX_READ)) ? 7'(MAX_READ)
                                                        : in_read_length;
            idx_r <= '0; found_r <= 1'b0; hitport_r <= 1'b0;
            freefound_r <= 1'b0; hit_r <= '0; free_r <= '0;
            if (in_action == ACT_HEADER) prem_r <= '0;
            if (in_action == ACT_HEADER || in_action == ACT_OPEN ||
                in_action == ACT_TICK)
              state_r <= (in_action == ACT_TICK) ? S_TICK : S_SCAN;
            else
              state_r <= S_DEC;
          end
        end
        // scan one slot per cycle for a match, or for a port clash and a free slot
        S_SCAN: begin
          if (act_r == ACT_HEADER) begin
            if (!found_r && slot_match) begin found_r <= 1'b1; hit_r <= idx; end
          end else begin
            if (used_r[idx] && lport_r[idx] == oport_r) hitport_r <= 1'b1;
            if (!used_r[idx] && !freefound_r) begin
              freefound_r <= 1'b1; free_r <= idx;
            end
          end
          if (idx_r == CW'(NUM_CONNS - 1)) state_r <= S_DEC;
          else idx_r <= idx_r + 1'b1;
        end
        // count down close-wait one slot per cycle
        S_TICK: begin
          if (used_r[idx] && cstate_r[idx] == CS_CWAIT) begin
            if (timer_r[idx] <= 16'd1) begin
              timer_r[idx] <= '0; cstate_r[idx] <= CS_CLOSED;
              bcnt_r[idx] <= '0; rptr_r[idx] <= '0;
              if (prem_r != 13'd0 && pslot_r == idx) prem_r <= '0;
            end else timer_r[idx] <= timer_r[idx] - 16'd1;
          end
          if (idx_r == CW'(NUM_CONNS - 1)) state_r <= S_IDLE;
          else idx_r <= idx_r + 1'b1;
        end
        // decide and emit a result; a payload byte taken emits none, a read goes on to S_RDREQ
        S_DEC: begin
          ov_r <= 1'b1; olast_r <= 1'b1; okind_r <= RK_STATUS;
          ostat_r <= ST_IGNORED; otype_r <= '0; osp_r <= '0; odp_r <= '0;
          onode_r <= '0; oseq_r <= '0; oack_r <= '0; osock_r <= '0;
          obyte_r <= '0;
          state_r <= S_IDLE;
          case (act_r)
            ACT_HEADER: begin
              if (found_r) begin
                logic rep;
                logic [2:0] rt;
                rep = 1'b0; rt = T_SYNACK;
                case (cstate_r[hit_r])
                  CS_LISTEN: if (typ_r == T_SYN) begin
                    rep = 1'b1; rport_r[hit_r] <= sp_r; eseq_r[hit_r] <= seq_r;
                    rnode_r[hit_r] <= node_r; cstate_r[hit_r] <= CS_CONN;
                  end
                  CS_CONN: begin
                    if (typ_r == T_SYN) rep = 1'b1;
                    else if (typ_r == T_FIN) begin
                      rep = 1'b1; rt = T_FINACK; cstate_r[hit_r] <= CS_CWAIT;
                      timer_r[hit_r] <= cwt_r;
                    end else if (typ_r == T_DATA &&
                                 sum_len <= LW'(BUF_BYTES)) begin
                      rep = 1'b1; rt = T_DATAACK;
                    end
                  end
                  CS_CWAIT: if (typ_r == T_FIN) begin rep = 1'b1; rt = T_FINACK; end
                  default: rep = 1'b0;
                endcase
                if (rep) begin
                  okind_r <= RK_SEG; ostat_r <= ST_OK; otype_r <= rt;
                  osp_r <= lport_r[hit_r];
                  odp_r <= (cstate_r[hit_r] == CS_LISTEN) ? sp_r : rport_r[hit_r];
                  onode_r <= node_r;
                  if (rt == T_DATAACK) begin
                    oseq_r <= '1;
                    if (seq_r == eseq_r[hit_r]) begin
                      oack_r <= eseq_r[hit_r] + {19'd0, len_r};
                      eseq_r[hit_r] <= eseq_r[hit_r] + {19'd0, len_r};
                      if (len_r != 13'd0) begin
                        pslot_r <= hit_r; prem_r <= len_r;
                      end
                    end else oack_r <= eseq_r[hit_r];
                  end
                end
              end
            end
            ACT_PAYLOAD: begin
              if (prem_r != 13'd0) begin
                ov_r <= 1'b0;
                if (bcnt_r[pslot_r] < BW'(BUF_BYTES))
                  bcnt_r[pslot_r] <= bcnt_r[pslot_r] + 1'b1;
                prem_r <= prem_r - 13'd1;
              end
            end
            ACT_OPEN: begin
              if (!hitport_r && freefound_r) begin
                ostat_r <= ST_OK; osock_r <= 3'(free_r);
                used_r[free_r] <= 1'b1; cstate_r[free_r] <= CS_CLOSED;
                lport_r[free_r] <= oport_r; rport_r[free_r] <= '0;
                rnode_r[free_r] <= '0; eseq_r[free_r] <= '0;
                bcnt_r[free_r] <= '0; rptr_r[free_r] <= '0;
                timer_r[free_r] <= '0;
              end else ostat_r <= ST_USED;
            end
            ACT_LISTEN, ACT_CLOSE, ACT_READ: begin
              if (!sid_ok) ostat_r <= ST_NOSOCK;
              else if (act_r == ACT_LISTEN) begin
                ostat_r <= ST_OK; cstate_r[sid] <= CS_LISTEN;
              end else if (act_r == ACT_CLOSE) begin
                if (cstate_r[sid] != CS_CLOSED) ostat_r <= ST_WRONG;
                else begin
                  ostat_r <= ST_OK;
                  if (prem_r != 13'd0 && pslot_r == sid) prem_r <= '0;
                  used_r[sid] <= 1'b0; cstate_r[sid] <= CS_CLOSED;
                  lport_r[sid] <= '0; rport_r[sid] <= '0; rnode_r[sid] <= '0;
                  eseq_r[sid] <= '0; bcnt_r[sid] <= '0; rptr_r[sid] <= '0;
                  timer_r[sid] <= '0;
                end
              end else begin
                if (bcnt_r[sid] < BW'(nread_r)) ostat_r <= ST_NODATA;
                else if (nread_r == 7'd0) ostat_r <= ST_OK;
                else begin
                  ov_r <= 1'b0; rcnt_r <= '0;
                  state_r <= S_RDREQ;
                end
              end
            end
            default: ostat_r <= ST_IGNORED;
          endcase
        end
        // issue buffer read; data lands next cycle
        S_RDREQ: begin
          rptr_r[sid] <= rptr_r[sid] + 1'b1;
          state_r <= S_RDOUT;
        end
        // emit one read byte per fetched word
        S_RDOUT: begin
          ov_r <= 1'b1; okind_r <= RK_BYTE; ostat_r <= ST_OK; otype_r <= '0;
          osp_r <= '0; odp_r <= '0; onode_r <= '0; oseq_r <= '0; oack_r <= '0;
          osock_r <= '0; obyte_r <= rd_q;
          olast_r <= (rcnt_r + 7'd1 == nread_r);
          rcnt_r <= rcnt_r + 7'd1;
          if (rcnt_r + 7'd1 == nread_r) begin
            bcnt_r[sid] <= bcnt_r[sid] - BW'(nread_r);
            state_r <= S_DONE;
          end else state_r <= S_RDREQ;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_result_kind = okind_r;
  assign out_status      = ostat_r;
  assign out_type        = otype_r;
  assign out_src_port    = osp_r;
  assign out_dest_port   = odp_r;
  assign out_dest_node   = onode_r;
  assign out_seq         = oseq_r;
  assign out_ack         = oack_r;
  assign out_socket_out  = osock_r;
  assign out_read_byte   = obyte_r;
  assign out_last        = olast_r;

endmodule
